// ===== hdl/c_int_literal_accumulator_assert.svh =====
// Assertion macros shared by the integer literal accumulator.
`ifndef C_INT_LITERAL_ACCUMULATOR_ASSERT_SVH
`define C_INT_LITERAL_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CILA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CILA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cila_pkg.sv =====
// Types and constants shared by the integer literal accumulator modules.
package cila_pkg;

  // Radix select codes.
  localparam logic [1:0] SEL_OCT = 2'd0;
  localparam logic [1:0] SEL_DEC = 2'd1;
  localparam logic [1:0] SEL_HEX = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_UU = 8'h55;
  localparam logic [7:0] CH_LU = 8'h75;
  localparam logic [7:0] CH_UL = 8'h4C;
  localparam logic [7:0] CH_LL = 8'h6C;

  // Literal kind codes.
  localparam logic [2:0] KIND_INT    = 3'd0;
  localparam logic [2:0] KIND_UINT   = 3'd1;
  localparam logic [2:0] KIND_LONG   = 3'd2;
  localparam logic [2:0] KIND_ULONG  = 3'd3;
  localparam logic [2:0] KIND_LLONG  = 3'd4;
  localparam logic [2:0] KIND_ULLONG = 3'd5;

  // Where the literal stands in its grammar.
  typedef enum logic [3:0] {
    PH_DIGITS = 4'b0001,
    PH_U      = 4'b0010,
    PH_L      = 4'b0100,
    PH_LL     = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       is_digit;
    logic       is_u;
    logic       is_l;
    logic [3:0] digit;
  } char_class_t;

  typedef struct packed {
    phase_t phase;
    logic   sticky;
    logic   unsigned_seen;
    logic   stray_seen;
  } lit_state_t;

  localparam lit_state_t LIT_RESET = '{
    phase:         PH_DIGITS,
    sticky:        1'b0,
    unsigned_seen: 1'b0,
    stray_seen:    1'b0
  };

endpackage

// ===== hdl/cila_char_dec.sv =====
// Character classifier: digit value within the radix, U and L suffix letters.
module cila_char_dec
  import cila_pkg::*;
(
  input  logic [7:0]  ch,
  input  logic [1:0]  base_sel,
  output char_class_t cls
);

  logic [3:0] raw;
  logic       num;
  logic [4:0] limit;

  always_comb begin
    raw = 4'd0;
    num = 1'b0;
    if (ch >= CH_0 && ch <= CH_9) begin
      num = 1'b1;
      raw = 4'(ch - CH_0);
    end else if (ch >= CH_UA && ch <= CH_UF) begin
      num = 1'b1;
      raw = 4'(ch - CH_UA) + 4'd10;
    end else if (ch >= CH_LA && ch <= CH_LF) begin
      num = 1'b1;
      raw = 4'(ch - CH_LA) + 4'd10;
    end
  end

  // An unused select code falls back to decimal.
  always_comb begin
    unique case (base_sel)
      SEL_OCT: limit = 5'd8;
      SEL_HEX: limit = 5'd16;
      default: limit = 5'd10;
    endcase
  end

  assign cls.is_digit = num && ({1'b0, raw} < limit);
  assign cls.digit    = raw;
  assign cls.is_u     = (ch == CH_UU) || (ch == CH_LU);
  assign cls.is_l     = (ch == CH_UL) || (ch == CH_LL);

endmodule

// ===== hdl/cila_step.sv =====
// Next-state logic for one character: accumulate a digit, advance the suffix, or flag a stray character.
module cila_step
  import cila_pkg::*;
#(
  parameter int ACC_WIDTH = 64
) (
  input  char_class_t          cls,
  input  logic [1:0]           base_sel,
  input  logic                 first_char,
  input  logic [ACC_WIDTH-1:0] accum,
  input  lit_state_t           st,
  output logic [ACC_WIDTH-1:0] accum_next,
  output lit_state_t           st_next
);

  logic [ACC_WIDTH-1:0] cur_acc;
  lit_state_t           cur;
  logic [ACC_WIDTH+3:0] ext;
  logic [ACC_WIDTH+3:0] prod;
  logic [ACC_WIDTH+3:0] sum;

  assign cur_acc = first_char ? '0 : accum;
  assign cur     = first_char ? LIT_RESET : st;
  assign ext     = {4'b0000, cur_acc};

  // Multiplying by a constant radix is shifts, plus one add for decimal.
  always_comb begin
    case (base_sel)
      SEL_OCT: prod = ext << 3;
      SEL_HEX: prod = ext << 4;
      default: prod = (ext << 3) + (ext << 1);
    endcase
  end

  assign sum = prod + {{ACC_WIDTH{1'b0}}, cls.digit};

  always_comb begin
    accum_next = cur_acc;
    st_next    = cur;
    if (cur.phase == PH_DIGITS && cls.is_digit) begin
      accum_next = sum[ACC_WIDTH-1:0];
      if (|sum[ACC_WIDTH+3:ACC_WIDTH]) begin
        st_next.sticky = 1'b1;
      end
    end else if (cur.phase == PH_DIGITS && cls.is_u) begin
      st_next.unsigned_seen = 1'b1;
      st_next.phase         = PH_U;
    end else if ((cur.phase == PH_DIGITS || cur.phase == PH_U) && cls.is_l) begin
      st_next.phase = PH_L;
    end else if (cur.phase == PH_L && cls.is_l) begin
      st_next.phase = PH_LL;
    end else begin
      st_next.stray_seen = 1'b1;
    end
  end

endmodule

// ===== hdl/c_int_literal_accumulator.sv =====
// Top level of the C integer literal accumulator.
//
// Characters of a literal arrive one request at a time on the char channel
// (ch, base_sel, first_char, last_char under char_valid / char_stall).
// first_char clears the accumulated state before its character is taken.
// The request carrying last_char produces one result on the result channel
// (value, too_big, kind, stray under result_valid / result_stall); other
// requests produce nothing.
// A request is held in an input register, then folded into the accumulator
// by the digit and suffix logic and, on the last character, written to the
// result register. Throughput is one character per cycle while char_stall is
// low, set by the single accumulator update between the two registers.
// While the receiver stalls, the result holds; characters that are not last
// keep flowing, and a last character waits in the input register, which
// raises char_stall until the pending result is taken.
// Reset empties both registers and returns the literal state to digits
// with a zero accumulator.
module c_int_literal_accumulator
  import cila_pkg::*;
#(
  parameter int ACC_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  ch,
  input  logic [1:0]  base_sel,
  input  logic        first_char,
  input  logic        last_char,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] value,
  output logic        too_big,
  output logic [2:0]  kind,
  output logic        stray
);

  logic                 in_vld;
  logic [7:0]           ch_q;
  logic [1:0]           sel_q;
  logic                 first_q;
  logic                 last_q;
  logic                 proc_go;
  logic                 char_fire;
  logic [ACC_WIDTH-1:0] accum;
  logic [ACC_WIDTH-1:0] accum_next;
  lit_state_t           st;
  lit_state_t           st_next;
  char_class_t          cls;
  logic [2:0]           kind_next;

  // A held character moves on unless it must write a result that is blocked.
  assign proc_go    = in_vld && (!last_q || !result_valid || !result_stall);
  assign char_stall = in_vld && !proc_go;
  assign char_fire  = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (char_fire) begin
      in_vld <= 1'b1;
    end else if (proc_go) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_fire) begin
      ch_q    <= ch;
      sel_q   <= base_sel;
      first_q <= first_char;
      last_q  <= last_char;
    end
  end

  cila_char_dec u_dec (
    .ch       (ch_q),
    .base_sel (sel_q),
    .cls      (cls)
  );

  cila_step #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_step (
    .cls        (cls),
    .base_sel   (sel_q),
    .first_char (first_q),
    .accum      (accum),
    .st         (st),
    .accum_next (accum_next),
    .st_next    (st_next)
  );

  // Literal state clears after every result.
  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= '0;
      st    <= LIT_RESET;
    end else if (proc_go) begin
      if (last_q) begin
        accum <= '0;
        st    <= LIT_RESET;
      end else begin
        accum <= accum_next;
        st    <= st_next;
      end
    end
  end

  always_comb begin
    unique case (st_next.phase)
      PH_L:    kind_next = st_next.unsigned_seen ? KIND_ULONG : KIND_LONG;
      PH_LL:   kind_next = st_next.unsigned_seen ? KIND_ULLONG : KIND_LLONG;
      default: kind_next = st_next.unsigned_seen ? KIND_UINT : KIND_INT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (proc_go && last_q) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && last_q) begin
      value   <= accum_next[31:0];
      too_big <= st_next.sticky || (|accum_next[ACC_WIDTH-1:32]);
      kind    <= kind_next;
      stray   <= st_next.stray_seen;
    end
  end

`include "c_int_literal_accumulator_assert.svh"

  `CILA_ASSERT_NEXT(a_clear_after_result, proc_go && last_q,
    accum == '0 && st == LIT_RESET, "literal state not cleared after a result")

  `CILA_ASSERT_NOW(a_stall_cause, char_stall,
    in_vld && last_q && result_valid && result_stall,
    "input stalled without a blocked result")

  `CILA_ASSERT_NEXT(a_hold_input, char_stall,
    in_vld && $stable(ch_q) && $stable(last_q), "held character changed while stalled")

  `CILA_ASSERT_NOW(a_kind_range, result_valid,
    kind <= KIND_ULLONG, "literal kind out of range")

endmodule
